[rtl/tbc_pkg.sv]
// Shared constants and payload types of the tetrahedron barycentric block.
`timescale 1ns / 1ps

package tbc_pkg;

    localparam int CHANNEL_BITS  = 16;
    localparam int FRACTION_BITS = 14;
    localparam int WEIGHT_BITS   = FRACTION_BITS + 6;
    localparam int CFG_BITS      = 3 * CHANNEL_BITS;
    localparam int DIFF_BITS     = CHANNEL_BITS + 1;
    localparam int CROSS_BITS    = 2 * DIFF_BITS + 1;
    localparam int PROD_BITS     = DIFF_BITS + CROSS_BITS;
    localparam int DOT_BITS      = PROD_BITS + 2;
    localparam int NUM_BITS      = DOT_BITS + FRACTION_BITS;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER_A = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER_B = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER_C = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER_D = 2'd3;

    typedef struct packed {
        logic signed [CHANNEL_BITS-1:0] pixel_red;
        logic signed [CHANNEL_BITS-1:0] pixel_green;
        logic signed [CHANNEL_BITS-1:0] pixel_blue;
    } t_pixel;

    typedef struct packed {
        logic signed [WEIGHT_BITS-1:0] weight_a;
        logic signed [WEIGHT_BITS-1:0] weight_b;
        logic signed [WEIGHT_BITS-1:0] weight_c;
        logic signed [WEIGHT_BITS-1:0] weight_d;
        logic                          singular;
        logic                          clipped;
    } t_weights;

endpackage

[rtl/tetrahedron_barycentric_coords.sv]
// Each pixel passes the offset, product, sum and divider set-up registers, the divider stages and the output register.
// Throughput is one pixel per cycle; a stalled output holds the whole pipeline in place.
// The divider is a chain of one-bit restoring stages, one register stage per quotient bit.
// After a configuration write, the corner matrix terms pass through r_col, r_cr, r_detp, r_det and then r_dabs.
// Synchronous active-low reset restores the default corners and clears all valid bits.
`timescale 1ns / 1ps

module tetrahedron_barycentric_coords (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tbc_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [tbc_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  tbc_pkg::t_pixel                      i_pixel,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output tbc_pkg::t_weights                    o_weights
);

    localparam int CB   = tbc_pkg::CHANNEL_BITS;
    localparam int FB   = tbc_pkg::FRACTION_BITS;
    localparam int WB   = tbc_pkg::WEIGHT_BITS;
    localparam int DW   = tbc_pkg::DIFF_BITS;
    localparam int XW   = tbc_pkg::CROSS_BITS;
    localparam int PW   = tbc_pkg::PROD_BITS;
    localparam int DOTW = tbc_pkg::DOT_BITS;
    localparam int NW   = tbc_pkg::NUM_BITS;
    localparam int CW   = tbc_pkg::CFG_BITS;

    logic [CW-1:0] r_corner [4];

    logic signed [DW-1:0]   r_col [3][3];
    logic signed [XW-1:0]   r_cr  [3][3];
    logic signed [PW-1:0]   r_detp [3];
    logic signed [DOTW-1:0] r_det;
    logic [DOTW-1:0]        r_dabs;
    logic                   r_dneg;
    logic                   r_dzero;

    logic en;

    logic signed [CB-1:0]   w_pix [3];
    logic signed [DW-1:0]   r_s1_v [3];
    logic                   r_s1_vld;
    logic signed [PW-1:0]   r_s2_p [3][3];
    logic                   r_s2_vld;
    logic signed [DOTW-1:0] r_s3_num [3];
    logic                   r_s3_vld;

    logic [DOTW-1:0] r_rem [WB+1][3];
    logic [WB-1:0]   r_low [WB+1][3];
    logic [WB-1:0]   r_q   [WB+1][3];
    logic            r_neg [WB+1][3];
    logic            r_ovf [WB+1][3];
    logic            r_vd  [WB+1];

    tbc_pkg::t_weights r_out;
    logic              r_ov;
    tbc_pkg::t_weights n_out;

    assign en          = !r_ov || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_ov;
    assign o_weights   = r_out;

    assign w_pix[0] = i_pixel.pixel_red;
    assign w_pix[1] = i_pixel.pixel_green;
    assign w_pix[2] = i_pixel.pixel_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner[0] <= CW'(1) << FB;
            r_corner[1] <= CW'(1) << (FB + CB);
            r_corner[2] <= CW'(1) << (FB + 2 * CB);
            r_corner[3] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tbc_pkg::CFG_CORNER_A: r_corner[0] <= i_cfg_data;
                tbc_pkg::CFG_CORNER_B: r_corner[1] <= i_cfg_data;
                tbc_pkg::CFG_CORNER_C: r_corner[2] <= i_cfg_data;
                tbc_pkg::CFG_CORNER_D: r_corner[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Columns a-d, b-d, c-d, cross products c1xc2, c2xc0, c0xc1, determinant and its flags.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                r_col[j][k] <= DW'($signed(r_corner[j][k*CB +: CB]))
                             - DW'($signed(r_corner[3][k*CB +: CB]));
            end
        end
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                r_cr[j][k] <= XW'(r_col[(j+1)%3][(k+1)%3] * r_col[(j+2)%3][(k+2)%3])
                            - XW'(r_col[(j+1)%3][(k+2)%3] * r_col[(j+2)%3][(k+1)%3]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            r_detp[k] <= PW'(r_col[0][k]) * PW'(r_cr[0][k]);
        end
        r_det   <= DOTW'(r_detp[0]) + DOTW'(r_detp[1]) + DOTW'(r_detp[2]);
        r_dneg  <= r_det[DOTW-1];
        r_dabs  <= r_det[DOTW-1] ? DOTW'(-r_det) : DOTW'(r_det);
        r_dzero <= (r_det == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_vd[0]  <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_vd[0]  <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DOTW-1:0] nabs;
        logic [NW-1:0]   nsh;
        logic [NW-1:0]   hi;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_s1_v[k] <= DW'(w_pix[k]) - DW'($signed(r_corner[3][k*CB +: CB]));
            end
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_s2_p[j][k] <= PW'(r_s1_v[k]) * PW'(r_cr[j][k]);
                end
                r_s3_num[j] <= DOTW'(r_s2_p[j][0]) + DOTW'(r_s2_p[j][1])
                             + DOTW'(r_s2_p[j][2]);
                nabs = r_s3_num[j][DOTW-1] ? DOTW'(-r_s3_num[j]) : DOTW'(r_s3_num[j]);
                nsh  = NW'(nabs) << FB;
                hi   = nsh >> WB;
                r_neg[0][j] <= r_s3_num[j][DOTW-1] ^ r_dneg;
                r_ovf[0][j] <= (hi >= NW'(r_dabs));
                r_rem[0][j] <= DOTW'(hi);
                r_low[0][j] <= nsh[WB-1:0];
                r_q[0][j]   <= '0;
            end
        end
    end

    for (genvar g = 1; g <= WB; g++) begin : g_div
        logic [DOTW:0] w_t [3];
        logic          w_ge [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                w_t[k]  = {r_rem[g-1][k], r_low[g-1][k][WB-1]};
                w_ge[k] = (w_t[k] >= {1'b0, r_dabs});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[g] <= 1'b0;
            end else if (en) begin
                r_vd[g] <= r_vd[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    r_rem[g][k] <= w_ge[k] ? DOTW'(w_t[k] - {1'b0, r_dabs}) : DOTW'(w_t[k]);
                    r_low[g][k] <= r_low[g-1][k] << 1;
                    r_q[g][k]   <= {r_q[g-1][k][WB-2:0], w_ge[k]};
                    r_neg[g][k] <= r_neg[g-1][k];
                    r_ovf[g][k] <= r_ovf[g-1][k];
                end
            end
        end
    end

    always_comb begin
        logic signed [WB-1:0] w [3];
        logic                 clip;
        logic                 big;
        logic signed [WB+1:0] sum;
        logic signed [WB-1:0] w3;
        clip = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r_neg[WB][k]) begin
                big = r_ovf[WB][k] || (r_q[WB][k] > (WB'(1) << (WB - 1)));
            end else begin
                big = r_ovf[WB][k] || (r_q[WB][k] > ((WB'(1) << (WB - 1)) - WB'(1)));
            end
            if (big) begin
                clip = 1'b1;
                w[k] = r_neg[WB][k] ? $signed(WB'(1) << (WB - 1))
                                    : $signed((WB'(1) << (WB - 1)) - WB'(1));
            end else begin
                w[k] = r_neg[WB][k] ? $signed(-r_q[WB][k]) : $signed(r_q[WB][k]);
            end
        end
        sum = $signed((WB + 2)'(1) << FB) - (WB + 2)'(w[0]) - (WB + 2)'(w[1])
            - (WB + 2)'(w[2]);
        if (sum > (WB + 2)'($signed((WB'(1) << (WB - 1)) - WB'(1)))) begin
            clip = 1'b1;
            w3   = $signed((WB'(1) << (WB - 1)) - WB'(1));
        end else if (sum < (WB + 2)'($signed(WB'(1) << (WB - 1)))) begin
            clip = 1'b1;
            w3   = $signed(WB'(1) << (WB - 1));
        end else begin
            w3 = WB'(sum);
        end
        if (r_dzero) begin
            n_out = '0;
            n_out.singular = 1'b1;
        end else begin
            n_out.weight_a = w[0];
            n_out.weight_b = w[1];
            n_out.weight_c = w[2];
            n_out.weight_d = w3;
            n_out.singular = 1'b0;
            n_out.clipped  = clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vd[WB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

[tb/tetrahedron_barycentric_coords_tb.sv]
// Self-checking testbench of the tetrahedron barycentric block: random stalls, config phases.
`timescale 1ns / 1ps

module tetrahedron_barycentric_coords_tb;

    localparam int LATENCY = tbc_pkg::WEIGHT_BITS + 5;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tbc_pkg::CFG_IDX_BITS-1:0] i_cfg_index = tbc_pkg::CFG_CORNER_A;
    logic [tbc_pkg::CFG_BITS-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    tbc_pkg::t_pixel i_pixel = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    tbc_pkg::t_weights o_weights;

    tetrahedron_barycentric_coords u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_pixel(i_pixel),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_weights(o_weights)
    );

    always #6 i_clk = ~i_clk;

    logic [tbc_pkg::CFG_BITS-1:0] corners [4];
    tbc_pkg::t_pixel pixel_q [$];
    tbc_pkg::t_weights weight_q [$];
    int errors = 0;
    int pixels_sent = 0;
    int weights_seen = 0;
    int singular_seen = 0;
    int clipped_seen = 0;
    int cycle = 0;
    bit hold_pixels = 1'b0;

    function automatic longint channel(logic [tbc_pkg::CFG_BITS-1:0] reg_val, int k);
        logic signed [tbc_pkg::CHANNEL_BITS-1:0] c;
        c = reg_val[k*tbc_pkg::CHANNEL_BITS +: tbc_pkg::CHANNEL_BITS];
        return longint'(c);
    endfunction

    function automatic logic signed [tbc_pkg::WEIGHT_BITS-1:0] saturate(
            logic signed [127:0] v, ref bit clip);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = (128'sd1 <<< (tbc_pkg::WEIGHT_BITS - 1)) - 1;
        lo_lim = -(128'sd1 <<< (tbc_pkg::WEIGHT_BITS - 1));
        if (v > hi_lim) begin
            clip = 1'b1;
            return hi_lim[tbc_pkg::WEIGHT_BITS-1:0];
        end
        if (v < lo_lim) begin
            clip = 1'b1;
            return lo_lim[tbc_pkg::WEIGHT_BITS-1:0];
        end
        return v[tbc_pkg::WEIGHT_BITS-1:0];
    endfunction

    function automatic tbc_pkg::t_weights solve_weights(tbc_pkg::t_pixel p);
        longint ca [3], cb [3], cc [3], v [3], x12 [3], x20 [3], x01 [3], dk, det;
        longint nums [3];
        logic signed [127:0] n, d, wsum;
        logic signed [tbc_pkg::WEIGHT_BITS-1:0] w [3];
        bit clip;
        tbc_pkg::t_weights r;
        clip = 1'b0;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            dk = channel(corners[tbc_pkg::CFG_CORNER_D], k);
            ca[k] = channel(corners[tbc_pkg::CFG_CORNER_A], k) - dk;
            cb[k] = channel(corners[tbc_pkg::CFG_CORNER_B], k) - dk;
            cc[k] = channel(corners[tbc_pkg::CFG_CORNER_C], k) - dk;
        end
        v[0] = longint'(p.pixel_red) - channel(corners[tbc_pkg::CFG_CORNER_D], 0);
        v[1] = longint'(p.pixel_green) - channel(corners[tbc_pkg::CFG_CORNER_D], 1);
        v[2] = longint'(p.pixel_blue) - channel(corners[tbc_pkg::CFG_CORNER_D], 2);
        x12[0] = cb[1]*cc[2] - cb[2]*cc[1];
        x12[1] = cb[2]*cc[0] - cb[0]*cc[2];
        x12[2] = cb[0]*cc[1] - cb[1]*cc[0];
        x20[0] = cc[1]*ca[2] - cc[2]*ca[1];
        x20[1] = cc[2]*ca[0] - cc[0]*ca[2];
        x20[2] = cc[0]*ca[1] - cc[1]*ca[0];
        x01[0] = ca[1]*cb[2] - ca[2]*cb[1];
        x01[1] = ca[2]*cb[0] - ca[0]*cb[2];
        x01[2] = ca[0]*cb[1] - ca[1]*cb[0];
        det = ca[0]*x12[0] + ca[1]*x12[1] + ca[2]*x12[2];
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        nums[0] = v[0]*x12[0] + v[1]*x12[1] + v[2]*x12[2];
        nums[1] = v[0]*x20[0] + v[1]*x20[1] + v[2]*x20[2];
        nums[2] = v[0]*x01[0] + v[1]*x01[1] + v[2]*x01[2];
        d = det;
        for (int k = 0; k < 3; k++) begin
            n = nums[k];
            n = n <<< tbc_pkg::FRACTION_BITS;
            w[k] = saturate(n / d, clip);
        end
        wsum = (128'sd1 <<< tbc_pkg::FRACTION_BITS) - w[0] - w[1] - w[2];
        r.weight_a = w[0];
        r.weight_b = w[1];
        r.weight_c = w[2];
        r.weight_d = saturate(wsum, clip);
        r.clipped = clip;
        return r;
    endfunction

    task automatic report_mismatch(string what, tbc_pkg::t_weights got,
                                   tbc_pkg::t_weights want);
        errors++;
        $display("MISMATCH %s: got %h want %h", what, got, want);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                weight_q.push_back(solve_weights(i_pixel));
                pixels_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pixel_q.size() > 0 && !hold_pixels) begin
                    i_in_valid <= 1'b1;
                    i_pixel <= pixel_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 60);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each transfer against the expected weights; stall pattern changes mode every so often.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (weight_q.size() == 0) begin
                    report_mismatch("unexpected transfer", o_weights, '0);
                end else begin
                    tbc_pkg::t_weights want;
                    want = weight_q.pop_front();
                    if (o_weights.weight_a !== want.weight_a)
                        report_mismatch("weight_a", o_weights, want);
                    if (o_weights.weight_b !== want.weight_b)
                        report_mismatch("weight_b", o_weights, want);
                    if (o_weights.weight_c !== want.weight_c)
                        report_mismatch("weight_c", o_weights, want);
                    if (o_weights.weight_d !== want.weight_d)
                        report_mismatch("weight_d", o_weights, want);
                    if (o_weights.singular !== want.singular)
                        report_mismatch("singular", o_weights, want);
                    if (o_weights.clipped !== want.clipped)
                        report_mismatch("clipped", o_weights, want);
                    singular_seen += want.singular;
                    clipped_seen += want.clipped;
                end
                weights_seen++;
            end
            if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= ($urandom_range(0, 1) != 0);
                default: i_out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle++;
        if (cycle > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle);
            $display("** tetrahedron_barycentric_coords: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pixel_q.size() > 0 || i_in_valid || weight_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_corner(logic [tbc_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [tbc_pkg::CFG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        corners[idx] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_gamut(logic [tbc_pkg::CFG_BITS-1:0] a, logic [tbc_pkg::CFG_BITS-1:0] b,
                             logic [tbc_pkg::CFG_BITS-1:0] c, logic [tbc_pkg::CFG_BITS-1:0] d);
        wait_drained();
        write_corner(tbc_pkg::CFG_CORNER_A, a);
        write_corner(tbc_pkg::CFG_CORNER_B, b);
        write_corner(tbc_pkg::CFG_CORNER_C, c);
        write_corner(tbc_pkg::CFG_CORNER_D, d);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [tbc_pkg::CFG_BITS-1:0] pack(int r, int g, int b);
        return {16'(b), 16'(g), 16'(r)};
    endfunction

    function automatic logic [tbc_pkg::CFG_BITS-1:0] random_corner();
        if ($urandom_range(0, 1) == 0)
            return {$urandom(), 16'($urandom())};
        return pack($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                    $urandom_range(0, 32767) - 16384);
    endfunction

    task automatic queue_pixel(int r, int g, int b);
        tbc_pkg::t_pixel p;
        p.pixel_red = 16'(r);
        p.pixel_green = 16'(g);
        p.pixel_blue = 16'(b);
        pixel_q.push_back(p);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) < 3)
                queue_pixel($urandom(), $urandom(), $urandom());
            else
                queue_pixel($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                            $urandom_range(0, 32768) - 16384);
        end
    endtask

    initial begin
        corners[tbc_pkg::CFG_CORNER_A] = pack(16384, 0, 0);
        corners[tbc_pkg::CFG_CORNER_B] = pack(0, 16384, 0);
        corners[tbc_pkg::CFG_CORNER_C] = pack(0, 0, 16384);
        corners[tbc_pkg::CFG_CORNER_D] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default gamut: corners, origin, field extremes.
        queue_pixel(0, 0, 0);
        queue_pixel(16384, 0, 0);
        queue_pixel(0, 16384, 0);
        queue_pixel(0, 0, 16384);
        queue_pixel(5461, 5461, 5461);
        queue_pixel(32767, 32767, 32767);
        queue_pixel(-32768, -32768, -32768);
        queue_pixel(32767, -32768, 0);
        queue_pixel(-1, -1, -1);
        queue_pixel(1, 1, 1);
        queue_random(200);

        // Pause the sender partway through until everything has drained.
        while (pixel_q.size() > 100) @(posedge i_clk);
        hold_pixels = 1'b1;
        while (weight_q.size() > 0 || i_in_valid) @(posedge i_clk);
        hold_pixels = 1'b0;
        queue_random(100);

        // Singular gamut: two coinciding corners.
        set_gamut(pack(100, 200, 300), pack(100, 200, 300), pack(-5, 7, 9), pack(0, 0, 0));
        queue_pixel(32767, 0, -32768);
        queue_random(40);

        // Unit determinant: heavy saturation.
        set_gamut(pack(1, 0, 0), pack(0, 1, 0), pack(0, 0, 1), pack(0, 0, 0));
        queue_pixel(32767, 32767, 32767);
        queue_pixel(-32768, -32768, -32768);
        queue_pixel(0, 0, 0);
        queue_pixel(1, 0, 0);
        queue_random(60);

        // Extreme corners.
        set_gamut(pack(32767, -32768, -32768), pack(-32768, 32767, -32768),
                  pack(-32768, -32768, 32767), pack(32767, 32767, 32767));
        queue_pixel(32767, 32767, 32767);
        queue_pixel(-32768, -32768, -32768);
        queue_random(150);

        set_gamut('1, {tbc_pkg::CFG_BITS{1'b1}} >> 1, '0,
                  {1'b1, {(tbc_pkg::CFG_BITS-1){1'b0}}});
        queue_random(100);

        for (int ph = 0; ph < 5; ph++) begin
            set_gamut(random_corner(), random_corner(), random_corner(), random_corner());
            queue_random(200);
        end

        wait_drained();
        $display("Covered %0d pixels and %0d weight sets over 10 gamut settings.",
                 pixels_sent, weights_seen);
        $display("Singular results %0d, clipped results %0d.", singular_seen, clipped_seen);
        if (errors == 0) begin
            $display("** tetrahedron_barycentric_coords: PASSED **");
        end else begin
            $display("** tetrahedron_barycentric_coords: FAILED **");
        end
        $finish;
    end

endmodule
